FILE: rtl/core/spct_pkg.sv
`default_nettype none

package spct_pkg;

	localparam int CORNER_WIDTH = 8;
	localparam logic [CORNER_WIDTH-1:0] CORNER_RESET = 8'd13;

	localparam logic KIND_CIRCLE = 1'b0;
	localparam logic KIND_RECT   = 1'b1;

	typedef enum logic [1:0] {
		MODE_CC,
		MODE_CR,
		MODE_RR
	} pair_mode_t;

	typedef struct packed {
		logic       valid;
		pair_mode_t mode;
		logic       pre_hit;
	} pair_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/shape_pair_collision_test.sv
`default_nettype none

// Tests one pair of 2D shapes (circle or centred rectangle) per transaction and
// reports a hit flag. A pair is taken on any cycle with start high; busy is
// always low, so a new pair may be given every cycle. The result comes out on
// hit with done high for one cycle, in the order the pairs went in; the
// receiver cannot stall and must take it then. Each pair passes the input
// register, the span and difference stage, the squaring multipliers and the
// compare stage, in that order. corner_radius may be written through
// cfg_wr_en and cfg_wr_data while no pair is in flight.

module shape_pair_collision_test import spct_pkg::*; #(
	parameter int COORD_WIDTH = 24
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [CORNER_WIDTH-1:0]       cfg_wr_data,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          a_kind,
	input  wire logic signed [COORD_WIDTH-1:0] a_x,
	input  wire logic signed [COORD_WIDTH-1:0] a_y,
	input  wire logic [COORD_WIDTH-2:0]        a_width,
	input  wire logic [COORD_WIDTH-2:0]        a_height,
	input  wire logic                          b_kind,
	input  wire logic signed [COORD_WIDTH-1:0] b_x,
	input  wire logic signed [COORD_WIDTH-1:0] b_y,
	input  wire logic [COORD_WIDTH-2:0]        b_width,
	input  wire logic [COORD_WIDTH-2:0]        b_height,
	output logic                               done,
	output logic                               hit
);

	localparam int DW = COORD_WIDTH + 3;
	localparam int MW = COORD_WIDTH + 2;

	logic [CORNER_WIDTH-1:0] corner_radius_q;

	logic                          valid_s1;
	logic                          a_kind_s1, b_kind_s1;
	logic signed [COORD_WIDTH-1:0] a_x_s1, a_y_s1, b_x_s1, b_y_s1;
	logic [COORD_WIDTH-2:0]        a_width_s1, a_height_s1, b_width_s1, b_height_s1;

	logic signed [DW-1:0] ax, ay, aw, ah, bx, by, bw, bh;
	logic signed [DW-1:0] cx, cy, cr, rx, ry, rw, rh;
	logic signed [DW-1:0] left, right, low, high;
	logic signed [DW-1:0] x0, x1, y0, y1, rr;
	logic                 in_x, in_y, edge_hit, rect_hit;
	pair_mode_t           mode;
	pair_ctrl_t           ctrl_d, ctrl_s2;
	logic [MW-1:0]        x0_s2, x1_s2, y0_s2, y1_s2, r_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_radius_q <= CORNER_RESET;
		end else if (cfg_wr_en) begin
			corner_radius_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			a_kind_s1   <= a_kind;
			a_x_s1      <= a_x;
			a_y_s1      <= a_y;
			a_width_s1  <= a_width;
			a_height_s1 <= a_height;
			b_kind_s1   <= b_kind;
			b_x_s1      <= b_x;
			b_y_s1      <= b_y;
			b_width_s1  <= b_width;
			b_height_s1 <= b_height;
		end
	end

	// doubled units make half sizes exact
	always_comb begin
		ax = DW'(a_x_s1) <<< 1;
		ay = DW'(a_y_s1) <<< 1;
		bx = DW'(b_x_s1) <<< 1;
		by = DW'(b_y_s1) <<< 1;
		aw = DW'(a_width_s1);
		ah = DW'(a_height_s1);
		bw = DW'(b_width_s1);
		bh = DW'(b_height_s1);
	end

	always_comb begin
		if (a_kind_s1 == KIND_CIRCLE && b_kind_s1 == KIND_CIRCLE) begin
			mode = MODE_CC;
		end else if (a_kind_s1 == KIND_RECT && b_kind_s1 == KIND_RECT) begin
			mode = MODE_RR;
		end else begin
			mode = MODE_CR;
		end
	end

	// circle first, rectangle second
	always_comb begin
		if (a_kind_s1 == KIND_CIRCLE) begin
			cx = ax; cy = ay; cr = aw;
			rx = bx; ry = by; rw = bw; rh = bh;
		end else begin
			cx = bx; cy = by; cr = bw;
			rx = ax; ry = ay; rw = aw; rh = ah;
		end
	end

	always_comb begin
		left  = rx - rw;
		right = rx + rw;
		low   = ry - rh;
		high  = ry + rh;
		in_x  = (left <= cx) && (cx <= right);
		in_y  = (low <= cy) && (cy <= high);
		if (in_x) begin
			edge_hit = ((low <= cy + cr) && (cy + cr <= high))
				|| ((low <= cy - cr) && (cy - cr <= high));
		end else if (in_y) begin
			edge_hit = ((left <= cx + cr) && (cx + cr <= right))
				|| ((left <= cx - cr) && (cx - cr <= right));
		end else begin
			edge_hit = 1'b0;
		end
		rect_hit = !((ax - aw >= bx + bw) || (ax + aw <= bx - bw)
			|| (ay - ah >= by + bh) || (ay + ah <= by - bh));
	end

	always_comb begin
		if (mode == MODE_CC) begin
			x0 = bx - ax;
			x1 = '0;
			y0 = by - ay;
			y1 = '0;
			rr = aw + bw;
		end else begin
			x0 = left - cx;
			x1 = right - cx;
			y0 = low - cy;
			y1 = high - cy;
			rr = cr + DW'({corner_radius_q, 1'b0});
		end
	end

	always_comb begin
		ctrl_d.valid   = valid_s1;
		ctrl_d.mode    = mode;
		ctrl_d.pre_hit = (mode == MODE_RR) ? rect_hit : ((mode == MODE_CR) && edge_hit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else begin
			ctrl_s2 <= ctrl_d;
		end
	end

	// magnitudes for the squaring stage
	always_ff @(posedge clk) begin
		x0_s2 <= x0[DW-1] ? MW'(-x0) : MW'(x0);
		x1_s2 <= x1[DW-1] ? MW'(-x1) : MW'(x1);
		y0_s2 <= y0[DW-1] ? MW'(-y0) : MW'(y0);
		y1_s2 <= y1[DW-1] ? MW'(-y1) : MW'(y1);
		r_s2  <= MW'(rr);
	end

	spct_disc_stage #(
		.MAG_WIDTH(MW)
	) u_disc (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl_s2 (ctrl_s2),
		.x0_s2   (x0_s2),
		.x1_s2   (x1_s2),
		.y0_s2   (y0_s2),
		.y1_s2   (y1_s2),
		.r_s2    (r_s2),
		.done    (done),
		.hit     (hit)
	);

`ifndef SYNTHESIS
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 4))
		else $error("result strobe without a matching transaction");

	a_stage_valid: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> ctrl_s2.valid)
		else $error("transaction dropped between stages");

	a_cc_no_prehit: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl_s2.valid && ctrl_s2.mode == MODE_CC) |-> !ctrl_s2.pre_hit)
		else $error("circle pair carries an early hit");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/spct_disc_stage.sv
`default_nettype none

module spct_disc_stage import spct_pkg::*; #(
	parameter int MAG_WIDTH = 26
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire pair_ctrl_t           ctrl_s2,
	input  wire logic [MAG_WIDTH-1:0] x0_s2,
	input  wire logic [MAG_WIDTH-1:0] x1_s2,
	input  wire logic [MAG_WIDTH-1:0] y0_s2,
	input  wire logic [MAG_WIDTH-1:0] y1_s2,
	input  wire logic [MAG_WIDTH-1:0] r_s2,
	output logic                      done,
	output logic                      hit
);

	localparam int SQ_WIDTH  = 2 * MAG_WIDTH;
	localparam int SUM_WIDTH = SQ_WIDTH + 1;

	pair_ctrl_t          ctrl_s3;
	logic [SQ_WIDTH-1:0] x0_sq_s3, x1_sq_s3, y0_sq_s3, y1_sq_s3, r_sq_s3;
	logic                d00, d01, d10, d11;
	logic                hit_d;
	logic                done_q, hit_q;

	// squares, one multiplier per operand
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s3 <= '0;
		end else begin
			ctrl_s3 <= ctrl_s2;
		end
	end

	always_ff @(posedge clk) begin
		x0_sq_s3 <= SQ_WIDTH'(x0_s2) * SQ_WIDTH'(x0_s2);
		x1_sq_s3 <= SQ_WIDTH'(x1_s2) * SQ_WIDTH'(x1_s2);
		y0_sq_s3 <= SQ_WIDTH'(y0_s2) * SQ_WIDTH'(y0_s2);
		y1_sq_s3 <= SQ_WIDTH'(y1_s2) * SQ_WIDTH'(y1_s2);
		r_sq_s3  <= SQ_WIDTH'(r_s2) * SQ_WIDTH'(r_s2);
	end

	// strict distance compares at each corner
	always_comb begin
		d00 = (SUM_WIDTH'(x0_sq_s3) + SUM_WIDTH'(y0_sq_s3)) < SUM_WIDTH'(r_sq_s3);
		d10 = (SUM_WIDTH'(x1_sq_s3) + SUM_WIDTH'(y0_sq_s3)) < SUM_WIDTH'(r_sq_s3);
		d01 = (SUM_WIDTH'(x0_sq_s3) + SUM_WIDTH'(y1_sq_s3)) < SUM_WIDTH'(r_sq_s3);
		d11 = (SUM_WIDTH'(x1_sq_s3) + SUM_WIDTH'(y1_sq_s3)) < SUM_WIDTH'(r_sq_s3);
	end

	always_comb begin
		unique case (ctrl_s3.mode)
			MODE_CC: hit_d = d00;
			MODE_CR: hit_d = ctrl_s3.pre_hit | d00 | d01 | d10 | d11;
			MODE_RR: hit_d = ctrl_s3.pre_hit;
			default: hit_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		hit_q <= hit_d;
	end

	assign done = done_q;
	assign hit  = hit_q;

`ifndef SYNTHESIS
	a_done_follows_valid: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(ctrl_s3.valid))
		else $error("result strobe without a transaction in flight");

	a_rect_pair_direct: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl_s3.valid && ctrl_s3.mode == MODE_RR) |=> (hit_q == $past(ctrl_s3.pre_hit)))
		else $error("rectangle pair result differs from overlap test");

	a_early_hit_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl_s3.valid && ctrl_s3.mode == MODE_CR && ctrl_s3.pre_hit) |=> hit_q)
		else $error("extreme point hit lost in circle rectangle test");
`endif

endmodule

`default_nettype wire
